### hdl/assert_macros.svh
// Assertion helpers, clocked on clk_i and idle while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed (same-cycle implication)");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed (next-cycle implication)");

`endif

### hdl/atrc_pkg.sv
package atrc_pkg;

  localparam int unsigned AngleW   = 12;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TenW     = 16;
  localparam int unsigned SecW     = 23;
  localparam int unsigned PmW      = 16;
  localparam int unsigned AccW     = 28;
  localparam int unsigned ProdW    = 40;
  localparam int unsigned GainW    = 13;
  localparam int unsigned GainSh   = 16;
  localparam int unsigned DqW      = 32;
  localparam int unsigned RemW     = 10;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 144;

  localparam logic [AngleW-1:0] AngleHalf = 12'd2048;
  localparam logic [GainW-1:0]  GainNum   = 13'd6844;
  localparam logic [TimeW-1:0]  MinGapMs  = 32'd10;
  localparam logic [RemW-1:0]   MsPerS    = 10'd1000;
  localparam logic [TenW-1:0]   Sat16     = 16'hFFFF;

  localparam logic [CfgAddrW-1:0] RegZeroAngle = 3'd0;
  localparam logic [CfgAddrW-1:0] RegZeroValid = 3'd1;
  localparam logic [CfgAddrW-1:0] RegPounds    = 3'd2;
  localparam logic [CfgAddrW-1:0] RegLength    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMult      = 3'd4;
  localparam logic [CfgAddrW-1:0] RegStart     = 3'd5;
  localparam logic [CfgAddrW-1:0] RegStop      = 3'd6;
  localparam logic [CfgAddrW-1:0] RegMinPull   = 3'd7;

  localparam logic [7:0]  RstPounds  = 8'd50;
  localparam logic [7:0]  RstLength  = 8'd60;
  localparam logic [7:0]  RstMult    = 8'd20;
  localparam logic [15:0] RstStart   = 16'd200;
  localparam logic [15:0] RstStop    = 16'd100;
  localparam logic [15:0] RstMinPull = 16'd1000;

  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvCounted = 2'd1;
  localparam logic [1:0] EvShort   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_DIV,
    ST_TEN,
    ST_EVAL,
    ST_SEC,
    ST_UPD
  } st_e;

endpackage

### hdl/angle_tension_rep_counter_unit.sv
// Band tension meter and pull counter.
// Input stream: one request per angle sample (tuser = mode: 0 sample, 1 clear
// statistics; tdata = angle and millisecond timestamp). Output stream: one
// result per request with tension, acceptance, pull state, pull event and the
// running statistics. Config channel writes one register per handshake and
// is always ready; write it only while the block is idle.
// A sample runs through a bit-serial multiplier (12 steps over the angle
// magnitude, then 13 steps over the gain constant) and a shared restoring
// divider (24 steps by band length); when a pull is counted the same divider
// spends 32 more steps on the seconds figure. A clear request skips the
// multiplier and the divider. A new request is taken only in the cycle after
// the previous result is loaded.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and worked on, and waits only for its final load.
// Reset sets registers to their defaults and clears all statistics.
`include "assert_macros.svh"

module angle_tension_rep_counter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] angle, [43:12] time_ms
  input  logic [atrc_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] tension_ckgf, [16] accepted, [17] pulling, [19:18] pull_event,
  // [35:20] pull_count, [67:36] training_ms, [90:68] last_pull_s,
  // [106:91] peak_ckgf, [138:107] ongoing_pull_ms
  output logic [atrc_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [atrc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [atrc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import atrc_pkg::*;

  // configuration
  logic [AngleW-1:0] zero_q;
  logic              zvalid_q;
  logic [7:0]        pounds_q, length_q, mult_q;
  logic [15:0]       start_q, stop_q, minpull_q;

  // control and datapath
  st_e                 state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                mode_q, mode_d;
  logic [TimeW-1:0]    time_q, time_d;
  logic [AngleW-1:0]   mag_q, mag_d;
  logic                mag_nz_q, mag_nz_d;
  logic [PmW-1:0]      pm_q, pm_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [DqW-1:0]      dq_q, dq_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [TenW-1:0]     ten_q, ten_d;
  logic                m_tvalid_q, m_tvalid_d;
  logic [OutDataW-1:0] out_q, out_d;

  // statistics
  logic [TimeW-1:0] last_acc_q, last_acc_d;
  logic             in_pull_q, in_pull_d;
  logic [TimeW-1:0] pull_start_q, pull_start_d;
  logic [15:0]      pull_cnt_q, pull_cnt_d;
  logic [TimeW-1:0] total_q, total_d;
  logic [SecW-1:0]  last_sec_q, last_sec_d;
  logic [TenW-1:0]  peak_q, peak_d;

  // input decode
  logic [AngleW-1:0] in_angle, in_diff, in_mag;
  logic [TimeW-1:0]  in_time;

  // divider step
  logic [RemW-1:0] dvs;
  logic [RemW:0]   div_sh;
  logic            div_ge;
  logic [RemW-1:0] div_rem;

  // decisions
  logic [TimeW-1:0] gap, dur;
  logic             take, pull_go, pull_end, counted;
  logic [TimeW:0]   sum;
  logic [1:0]       ev;
  logic [TimeW-1:0] ongoing;

  assign in_angle = s_axis_tdata[AngleW-1:0];
  assign in_time  = s_axis_tdata[AngleW+TimeW-1:AngleW];
  assign in_diff  = in_angle - zero_q;
  assign in_mag   = (in_diff > AngleHalf) ? (12'd0 - in_diff) : in_diff;

  assign dvs     = (state_q == ST_SEC) ? MsPerS : {2'b00, length_q};
  assign div_sh  = {rem_q, dq_q[DqW-1]};
  assign div_ge  = div_sh >= {1'b0, dvs};
  assign div_rem = div_ge ? RemW'(div_sh - {1'b0, dvs}) : div_sh[RemW-1:0];

  assign gap      = time_q - last_acc_q;
  assign dur      = time_q - pull_start_q;
  assign take     = !mode_q && (gap >= MinGapMs);
  assign pull_go  = take && !in_pull_q && (ten_q >= start_q);
  assign pull_end = take && in_pull_q && (ten_q <= stop_q);
  assign counted  = pull_end && (dur >= {16'd0, minpull_q});
  assign sum      = {1'b0, total_q} + {1'b0, dur};
  assign ev       = counted ? EvCounted : (pull_end ? EvShort : EvNone);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q    <= '0;
      zvalid_q  <= 1'b0;
      pounds_q  <= RstPounds;
      length_q  <= RstLength;
      mult_q    <= RstMult;
      start_q   <= RstStart;
      stop_q    <= RstStop;
      minpull_q <= RstMinPull;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        RegZeroAngle: zero_q    <= cfg_data_i[AngleW-1:0];
        RegZeroValid: zvalid_q  <= cfg_data_i[0];
        RegPounds:    pounds_q  <= cfg_data_i[7:0];
        RegLength:    length_q  <= cfg_data_i[7:0];
        RegMult:      mult_q    <= cfg_data_i[7:0];
        RegStart:     start_q   <= cfg_data_i;
        RegStop:      stop_q    <= cfg_data_i;
        RegMinPull:   minpull_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_tvalid_q   <= 1'b0;
      last_acc_q   <= '0;
      in_pull_q    <= 1'b0;
      pull_start_q <= '0;
      pull_cnt_q   <= '0;
      total_q      <= '0;
      last_sec_q   <= '0;
      peak_q       <= '0;
    end else begin
      state_q      <= state_d;
      m_tvalid_q   <= m_tvalid_d;
      last_acc_q   <= last_acc_d;
      in_pull_q    <= in_pull_d;
      pull_start_q <= pull_start_d;
      pull_cnt_q   <= pull_cnt_d;
      total_q      <= total_d;
      last_sec_q   <= last_sec_d;
      peak_q       <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mode_q   <= mode_d;
    time_q   <= time_d;
    mag_q    <= mag_d;
    mag_nz_q <= mag_nz_d;
    pm_q     <= pm_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    ten_q    <= ten_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mode_d       = mode_q;
    time_d       = time_q;
    mag_d        = mag_q;
    mag_nz_d     = mag_nz_q;
    pm_d         = pm_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    ten_d        = ten_q;
    out_d        = out_q;
    m_tvalid_d   = m_tvalid_q && !m_axis_tready;
    last_acc_d   = last_acc_q;
    in_pull_d    = in_pull_q;
    pull_start_d = pull_start_q;
    pull_cnt_d   = pull_cnt_q;
    total_d      = total_q;
    last_sec_d   = last_sec_q;
    peak_d       = peak_q;
    ongoing      = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d   = s_axis_tuser;
          time_d   = in_time;
          mag_d    = in_mag;
          mag_nz_d = |in_mag;
          pm_d     = {8'd0, pounds_q} * {8'd0, mult_q};
          acc_d    = '0;
          prod_d   = '0;
          ten_d    = '0;
          cnt_d    = CntW'(AngleW - 1);
          state_d  = s_axis_tuser ? ST_UPD : ST_MULA;
        end
      end
      ST_MULA: begin
        acc_d = {acc_q[AccW-2:0], 1'b0} + (mag_q[AngleW-1] ? AccW'(pm_q) : '0);
        mag_d = {mag_q[AngleW-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = CntW'(GainW - 1);
          state_d = ST_MULB;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MULB: begin
        prod_d = {prod_q[ProdW-2:0], 1'b0} +
                 (GainNum[cnt_q[3:0]] ? ProdW'(acc_q) : '0);
        if (cnt_q == '0) begin
          dq_d    = {prod_d[ProdW-1:GainSh], 8'd0};
          rem_d   = '0;
          cnt_d   = CntW'(ProdW - GainSh - 1);
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV, ST_SEC: begin
        dq_d  = {dq_q[DqW-2:0], div_ge};
        rem_d = div_rem;
        if (cnt_q == '0) begin
          state_d = (state_q == ST_DIV) ? ST_TEN : ST_UPD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_TEN: begin
        if (!zvalid_q) begin
          ten_d = '0;
        end else if (length_q == '0) begin
          ten_d = (mag_nz_q && (pm_q != '0)) ? Sat16 : '0;
        end else if (dq_q[23:16] != '0) begin
          ten_d = Sat16;
        end else begin
          ten_d = dq_q[15:0];
        end
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (counted) begin
          dq_d    = dur;
          rem_d   = '0;
          cnt_d   = CntW'(DqW - 1);
          state_d = ST_SEC;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!m_tvalid_q || m_axis_tready) begin
          if (mode_q) begin
            pull_cnt_d   = '0;
            total_d      = '0;
            last_sec_d   = '0;
            peak_d       = '0;
            in_pull_d    = 1'b0;
            pull_start_d = time_q;
          end else if (take) begin
            last_acc_d = time_q;
            if (ten_q > peak_q) begin
              peak_d = ten_q;
            end
            if (pull_go) begin
              in_pull_d    = 1'b1;
              pull_start_d = time_q;
              last_sec_d   = '0;
            end
            if (pull_end) begin
              in_pull_d = 1'b0;
            end
            if (counted) begin
              if (pull_cnt_q != Sat16) begin
                pull_cnt_d = pull_cnt_q + 1'b1;
              end
              total_d    = sum[TimeW] ? '1 : sum[TimeW-1:0];
              last_sec_d = dq_q[SecW-1:0];
            end
          end
          ongoing    = in_pull_d ? (time_q - pull_start_d) : '0;
          out_d      = {5'd0, ongoing, peak_d, last_sec_d, total_d, pull_cnt_d,
                        (mode_q ? EvNone : ev), in_pull_d, take, ten_q};
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_cnt_only_on_commit, pull_cnt_q != $past(pull_cnt_q), $past(state_q) == ST_UPD)
  `ASSERT_IMPL(a_count_after_seconds, state_q == ST_UPD && counted, $past(state_q) == ST_SEC || $past(state_q) == ST_UPD)
  `ASSERT_IMPL(a_peak_covers_result, m_tvalid_q && out_q[16], out_q[106:91] >= out_q[15:0])

endmodule

### tb/angle_tension_rep_counter_unit_test.sv
module angle_tension_rep_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import atrc_pkg::*;

  localparam int HalfTurn = 2048;
  localparam int FullTurn = 4096;

  typedef struct packed {
    logic [15:0] tension;
    logic        accepted;
    logic        pulling;
    logic [1:0]  pull_ev;
    logic [15:0] pulls;
    logic [31:0] train_ms;
    logic [22:0] last_s;
    logic [15:0] peak;
    logic [31:0] ongoing;
  } sample_result_t;

  typedef struct packed {
    logic                is_write;
    logic [CfgAddrW-1:0] addr;
    logic [15:0]         data;
    logic                mode;
    logic [11:0]         angle;
    logic [31:0]         now;
    logic                typed;
    sample_result_t      want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  angle_tension_rep_counter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow registers
  logic [11:0] zero_angle_r = '0;
  logic        zero_valid_r = 1'b0;
  logic [7:0]  pounds_r     = RstPounds;
  logic [7:0]  length_r     = RstLength;
  logic [7:0]  mult_r       = RstMult;
  logic [15:0] start_r      = RstStart;
  logic [15:0] stop_r       = RstStop;
  logic [15:0] min_pull_r   = RstMinPull;

  // shadow statistics
  logic [31:0] last_accept_r = '0;
  logic        in_pull_r     = 1'b0;
  logic [31:0] pull_start_r  = '0;
  logic [15:0] pulls_r       = '0;
  logic [31:0] train_r       = '0;
  logic [22:0] last_s_r      = '0;
  logic [15:0] peak_r        = '0;

  sample_result_t pending[$];
  sample_result_t seen;
  logic           no_idle = 1'b0;
  int             errors = 0;
  int             results_seen = 0;

  assign seen = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17],
                 m_axis_tdata[19:18], m_axis_tdata[35:20], m_axis_tdata[67:36],
                 m_axis_tdata[90:68], m_axis_tdata[106:91], m_axis_tdata[138:107]};

  function automatic logic [15:0] scaled_tension(logic [63:0] mag, logic [7:0] pounds,
                                                 logic [7:0] len, logic [7:0] mult);
    logic [63:0] num;
    logic [63:0] q;
    num = mag * 64'(pounds) * 64'(mult) * 64'(GainNum);
    if (len == 8'd0) return (num == 64'd0) ? 16'd0 : Sat16;
    q = num / (64'(len) << GainSh);
    return (q > 64'(Sat16)) ? Sat16 : q[15:0];
  endfunction

  function automatic logic [15:0] angle_tension(logic [11:0] angle);
    int d;
    if (!zero_valid_r) return 16'd0;
    d = int'(angle) - int'(zero_angle_r);
    if (d > HalfTurn) d -= FullTurn;
    else if (d < -HalfTurn) d += FullTurn;
    return scaled_tension(64'((d < 0) ? -d : d), pounds_r, length_r, mult_r);
  endfunction

  function automatic sample_result_t predict_step(logic mode, logic [11:0] angle,
                                                  logic [31:0] now);
    sample_result_t r;
    logic [31:0] dur;
    r = '0;
    r.pull_ev = EvNone;
    if (mode) begin
      pulls_r = '0;
      train_r = '0;
      last_s_r = '0;
      peak_r = '0;
      in_pull_r = 1'b0;
      pull_start_r = now;
    end else begin
      r.tension = angle_tension(angle);
      if (now - last_accept_r >= MinGapMs) begin
        r.accepted = 1'b1;
        last_accept_r = now;
        if (r.tension > peak_r) peak_r = r.tension;
        if (!in_pull_r) begin
          if (r.tension >= start_r) begin
            in_pull_r = 1'b1;
            pull_start_r = now;
            last_s_r = '0;
          end
        end else if (r.tension <= stop_r) begin
          dur = now - pull_start_r;
          in_pull_r = 1'b0;
          if (dur >= 32'(min_pull_r)) begin
            if (pulls_r != Sat16) pulls_r = pulls_r + 16'd1;
            train_r = (train_r > ~dur) ? 32'hFFFF_FFFF : train_r + dur;
            last_s_r = 23'(dur / MsPerS);
            r.pull_ev = EvCounted;
          end else begin
            r.pull_ev = EvShort;
          end
        end
      end
    end
    r.pulling  = in_pull_r;
    r.pulls    = pulls_r;
    r.train_ms = train_r;
    r.last_s   = last_s_r;
    r.peak     = peak_r;
    r.ongoing  = in_pull_r ? now - pull_start_r : 32'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got 0x%0h, want 0x%0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    sample_result_t want;
    if (rst_ni) begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 17);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending.size() == 0) begin
          report_mismatch("result with no request pending", 32'd0, 32'd0);
        end else begin
          want = pending.pop_front();
          if (seen.tension !== want.tension)
            report_mismatch("tension_ckgf", 32'(seen.tension), 32'(want.tension));
          if (seen.accepted !== want.accepted)
            report_mismatch("accepted", 32'(seen.accepted), 32'(want.accepted));
          if (seen.pulling !== want.pulling)
            report_mismatch("pulling", 32'(seen.pulling), 32'(want.pulling));
          if (seen.pull_ev !== want.pull_ev)
            report_mismatch("pull_event", 32'(seen.pull_ev), 32'(want.pull_ev));
          if (seen.pulls !== want.pulls)
            report_mismatch("pull_count", 32'(seen.pulls), 32'(want.pulls));
          if (seen.train_ms !== want.train_ms)
            report_mismatch("training_ms", seen.train_ms, want.train_ms);
          if (seen.last_s !== want.last_s)
            report_mismatch("last_pull_s", 32'(seen.last_s), 32'(want.last_s));
          if (seen.peak !== want.peak)
            report_mismatch("peak_ckgf", 32'(seen.peak), 32'(want.peak));
          if (seen.ongoing !== want.ongoing)
            report_mismatch("ongoing_pull_ms", seen.ongoing, want.ongoing);
        end
        results_seen++;
      end
    end
  end

  task automatic send_request(logic mode, logic [11:0] angle, logic [31:0] now,
                              logic typed, sample_result_t want);
    sample_result_t pred;
    cfg_valid_i <= 1'b0;
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, now, angle};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pred = predict_step(mode, angle, now);
    pending.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    case (addr)
      RegZeroAngle: zero_angle_r = data[11:0];
      RegZeroValid: zero_valid_r = data[0];
      RegPounds:    pounds_r     = data[7:0];
      RegLength:    length_r     = data[7:0];
      RegMult:      mult_r       = data[7:0];
      RegStart:     start_r      = data;
      RegStop:      stop_r       = data;
      RegMinPull:   min_pull_r   = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] za, logic [15:0] zv, logic [15:0] pounds,
                            logic [15:0] len, logic [15:0] mult, logic [15:0] start,
                            logic [15:0] stop, logic [15:0] min_pull);
    drain_results();
    write_reg(RegZeroAngle, za);
    write_reg(RegZeroValid, zv);
    write_reg(RegPounds, pounds);
    write_reg(RegLength, len);
    write_reg(RegMult, mult);
    write_reg(RegStart, start);
    write_reg(RegStop, stop);
    write_reg(RegMinPull, min_pull);
  endtask

  function automatic stim_row_t wr_row(logic [CfgAddrW-1:0] addr, logic [15:0] data);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(logic mode, logic [11:0] angle, logic [31:0] now);
    stim_row_t row;
    row = '0;
    row.mode = mode;
    row.angle = angle;
    row.now = now;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic mode, logic [11:0] angle, logic [31:0] now,
                                          sample_result_t want);
    stim_row_t row;
    row = item_row(mode, angle, now);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t      directed[$];
    sample_result_t known;
    logic [31:0]    now;
    logic [11:0]    ofs;
    logic [11:0]    angle;
    logic [7:0]     pw;
    logic [7:0]     lw;
    logic [7:0]     mw;
    logic [15:0]    tmax;
    logic [15:0]    start;
    logic           mode;
    logic           hi;
    int             hold;
    int             r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // uncalibrated after reset: first sample is rate limited, second accepted
    known = '0;
    directed.push_back(known_row(1'b0, 12'd0, 32'd0, known));
    known.accepted = 1'b1;
    directed.push_back(known_row(1'b0, 12'd4095, 32'd10, known));
    directed.push_back(wr_row(RegZeroValid, 16'd1));
    // full half turn, wrap past half turn, short pull, counted pull, clear
    directed.push_back(item_row(1'b0, 12'd2048, 32'd20));
    directed.push_back(item_row(1'b0, 12'd2049, 32'd25));
    directed.push_back(item_row(1'b0, 12'd0, 32'd520));
    directed.push_back(item_row(1'b0, 12'd4095, 32'd600));
    directed.push_back(item_row(1'b0, 12'd2048, 32'd1000));
    directed.push_back(item_row(1'b0, 12'd2048, 32'd1500));
    directed.push_back(item_row(1'b0, 12'd0, 32'd2000));
    known = '0;
    directed.push_back(known_row(1'b1, 12'd2048, 32'd2100, known));
    // maximum gain, saturation, zero minimum pull
    directed.push_back(wr_row(RegPounds, 16'd255));
    directed.push_back(wr_row(RegMult, 16'd255));
    directed.push_back(wr_row(RegLength, 16'd1));
    directed.push_back(wr_row(RegMinPull, 16'd0));
    directed.push_back(item_row(1'b0, 12'd1, 32'd2200));
    directed.push_back(item_row(1'b0, 12'd2048, 32'd2210));
    directed.push_back(item_row(1'b0, 12'd0, 32'd2215));
    directed.push_back(item_row(1'b0, 12'd0, 32'd2220));
    // zero band length
    directed.push_back(wr_row(RegLength, 16'd0));
    directed.push_back(item_row(1'b0, 12'd5, 32'd2300));
    directed.push_back(item_row(1'b0, 12'd0, 32'd2400));
    // zero gain with zero levels
    directed.push_back(wr_row(RegMult, 16'd0));
    directed.push_back(wr_row(RegStart, 16'd0));
    directed.push_back(wr_row(RegStop, 16'd0));
    directed.push_back(item_row(1'b0, 12'd100, 32'd2500));
    directed.push_back(item_row(1'b0, 12'd100, 32'd2600));
    // defaults back, oversized zero angle, pull across the time wrap, calibration off
    directed.push_back(wr_row(RegLength, 16'(RstLength)));
    directed.push_back(wr_row(RegMult, 16'(RstMult)));
    directed.push_back(wr_row(RegPounds, 16'(RstPounds)));
    directed.push_back(wr_row(RegStart, RstStart));
    directed.push_back(wr_row(RegStop, RstStop));
    directed.push_back(wr_row(RegMinPull, RstMinPull));
    directed.push_back(wr_row(RegZeroAngle, 16'hFFFF));
    directed.push_back(item_row(1'b0, 12'd2047, 32'hFFFF_FFF0));
    directed.push_back(item_row(1'b0, 12'd2047, 32'hFFFF_FFFF));
    directed.push_back(item_row(1'b0, 12'd4095, 32'h0000_0400));
    directed.push_back(wr_row(RegZeroValid, 16'hFFFE));
    directed.push_back(item_row(1'b0, 12'd123, 32'h0000_1000));

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        drain_results();
        write_reg(directed[i].addr, directed[i].data);
      end else begin
        send_request(directed[i].mode, directed[i].angle, directed[i].now,
                     directed[i].typed, directed[i].want);
      end
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(16'($urandom_range(0, 4095)), 16'd1, 16'(RstPounds), 16'(RstLength),
                      16'(RstMult), RstStart, RstStop, RstMinPull);
        2: set_config(16'd4095, 16'd1, 16'd255, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF,
                      16'hFFFF);
        4: set_config(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        5: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: begin
          pw = (p == 6) ? 8'd255 : 8'($urandom_range(1, 255));
          lw = (p == 6) ? 8'd1 : 8'($urandom_range(1, 255));
          mw = (p == 6) ? 8'd255 : 8'($urandom_range(1, 255));
          tmax = scaled_tension(64'd2048, pw, lw, mw);
          start = 16'($urandom_range(0, tmax));
          set_config(16'($urandom_range(0, 4095)), 16'd1, 16'(pw), 16'(lw), 16'(mw), start,
                     16'($urandom_range(0, start)), 16'($urandom_range(0, 3000)));
        end
      endcase
      no_idle = (p == 3);
      now = $urandom;
      hi = 1'b0;
      hold = 1;
      for (int n = 0; n < 222; n++) begin
        r = $urandom_range(0, 99);
        mode = (r < 2);
        if (r < 12) begin
          angle = 12'($urandom);
        end else begin
          ofs = hi ? 12'($urandom_range(64, 2048)) : 12'($urandom_range(0, 16));
          angle = $urandom_range(0, 1) ? zero_angle_r + ofs : zero_angle_r - ofs;
        end
        r = $urandom_range(0, 99);
        if (r < 8) now = now + 32'($urandom_range(0, 9));
        else if (r < 12) now = now + $urandom;
        else now = now + 32'($urandom_range(10, 400));
        send_request(mode, angle, now, 1'b0, '0);
        hold = hold - 1;
        if (hold == 0) begin
          hi = !hi;
          hold = $urandom_range(1, 8);
        end
      end
      no_idle = 1'b0;
    end

    drain_results();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("angle_tension_rep_counter_unit_test: done, clean");
    end else begin
      $display("angle_tension_rep_counter_unit_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("angle_tension_rep_counter_unit_test: done, errors");
    $finish;
  end

endmodule
